// ===== src/qrb_pkg.sv =====
// ----------------------------------------------------------------------------
// qrb_pkg
// Shared constants, codes and controller/datapath interface types for the
// quartered receive ring buffer.
// ----------------------------------------------------------------------------
package qrb_pkg;

    localparam int BUF_DEPTH    = 1024;
    localparam int MAX_FETCH    = 64;
    localparam int NUM_QUARTERS = 4;
    localparam int QSIZE        = BUF_DEPTH / NUM_QUARTERS;

    localparam int ADDR_W  = $clog2(BUF_DEPTH);
    localparam int Q_W     = $clog2(NUM_QUARTERS);
    localparam int OFS_W   = ADDR_W - Q_W;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int AVAIL_W = 10;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [OFS_W-1:0] OFS_MAX      = OFS_W'(QSIZE - 1);
    localparam logic [LEN_W-1:0] MAX_FETCH_LEN = LEN_W'(MAX_FETCH);

    // request kind carried in tuser
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef struct packed {
        logic wr;       // store arriving byte
        logic fetch;    // latch fetch request
        logic issue;    // issue one read / empty-grant result
    } qrb_cmd_t;

    typedef struct packed {
        logic q_free;   // read stage can take a new entry
        logic cnt_one;  // current issue is the final one of the fetch
    } qrb_sts_t;

endpackage

// ===== src/quartered_rx_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// quartered_rx_ring_buffer
// Receive ring buffer of four quarters with oldest-data overwrite and
// clamped fetches returning one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests; tuser[0] selects a byte arrival or a fetch.
//   A byte arrival is stored in the byte store and produces no output.
//   A fetch produces max(granted,1) m_axis transactions; tlast marks the
//   final one and tuser[0] is low for an empty grant.
//   A fetch's first byte passes the fetch registers, the read stage and
//   the output register. Bytes then follow one per cycle while m_axis is
//   ready, set by the store's single read port and registered read stage.
//   s_axis_tready drops from the fetch transaction until the last read of
//   that fetch is issued.
//   When m_axis stalls, the read stage and output register hold two bytes
//   and further reads wait; nothing is lost.
//   Reset clears the write quarter, write offset and read pointer; the byte
//   store contents stay undefined until written.
// ----------------------------------------------------------------------------
module quartered_rx_ring_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] rx_byte, [14:8] fetch_length, [15] from_back, [16] consume
    input  logic [qrb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] data_byte, [14:8] granted_length, [24:15] bytes_available
    output logic [qrb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] data_valid
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import qrb_pkg::*;

    qrb_cmd_t cmd;
    qrb_sts_t sts;

    logic [BYTE_W-1:0]  data_byte;
    logic               data_valid;
    logic [LEN_W-1:0]   granted_length;
    logic [AVAIL_W-1:0] bytes_available;

    qrb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_req_type (s_axis_tuser[0]),
        .s_ready    (s_axis_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    qrb_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .rx_byte         (s_axis_tdata[7:0]),
        .fetch_length    (s_axis_tdata[14:8]),
        .from_back       (s_axis_tdata[15]),
        .consume         (s_axis_tdata[16]),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .data_byte       (data_byte),
        .data_valid      (data_valid),
        .granted_length  (granted_length),
        .bytes_available (bytes_available),
        .last            (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, bytes_available, granted_length, data_byte};
    assign m_axis_tuser = data_valid;

endmodule

// ===== src/qrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// qrb_ctrl
// Controller: takes input transactions and sequences the reads of a fetch.
// ----------------------------------------------------------------------------
module qrb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_req_type,
    output logic             s_ready,
    input  qrb_pkg::qrb_sts_t sts,
    output qrb_pkg::qrb_cmd_t cmd
);
    import qrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_FETCH) begin
                        cmd.fetch  = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (sts.q_free) begin
                    cmd.issue = 1'b1;
                    if (sts.cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/qrb_dp.sv =====
// ----------------------------------------------------------------------------
// qrb_dp
// Datapath: byte store, write/read pointers, fetch length clamp, read stage
// and output register.
// ----------------------------------------------------------------------------
module qrb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qrb_pkg::qrb_cmd_t             cmd,
    output qrb_pkg::qrb_sts_t             sts,
    input  logic [qrb_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [qrb_pkg::LEN_W-1:0]     fetch_length,
    input  logic                          from_back,
    input  logic                          consume,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qrb_pkg::BYTE_W-1:0]    data_byte,
    output logic                          data_valid,
    output logic [qrb_pkg::LEN_W-1:0]     granted_length,
    output logic [qrb_pkg::AVAIL_W-1:0]   bytes_available,
    output logic                          last
);
    import qrb_pkg::*;

    logic [BYTE_W-1:0] mem [BUF_DEPTH];

    // pointers
    logic [Q_W-1:0]    wq_reg, wq_next;
    logic [OFS_W-1:0]  wofs_reg, wofs_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;

    // fetch sequencing
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               empty_reg, empty_next;
    logic [LEN_W-1:0]   grant_reg, grant_next;
    logic [AVAIL_W-1:0] avail_reg, avail_next;

    // read stage
    logic               q_vld_reg, q_vld_next;
    logic               q_last_reg, q_dvalid_reg;
    logic [LEN_W-1:0]   q_grant_reg;
    logic [AVAIL_W-1:0] q_avail_reg;
    logic [BYTE_W-1:0]  mem_q_reg;

    // output register
    logic               out_vld_reg, out_vld_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_dvalid_reg, out_last_reg;
    logic [LEN_W-1:0]   out_grant_reg;
    logic [AVAIL_W-1:0] out_avail_reg;

    logic [ADDR_W-1:0]  w_idx;
    logic [ADDR_W-1:0]  avail_now;
    logic [LEN_W-1:0]   len_sat;
    logic [LEN_W-1:0]   g;
    logic [Q_W-1:0]     wq_inc;
    logic               q_move;

    assign w_idx     = {wq_reg, wofs_reg};
    assign avail_now = w_idx - rp_reg;
    assign len_sat   = (fetch_length > MAX_FETCH_LEN) ? MAX_FETCH_LEN : fetch_length;
    assign g         = ({{(ADDR_W-LEN_W){1'b0}}, len_sat} > avail_now)
                       ? avail_now[LEN_W-1:0] : len_sat;
    assign wq_inc    = wq_reg + Q_W'(1);

    assign q_move      = q_vld_reg && (!out_vld_reg || m_ready);
    assign sts.q_free  = !q_vld_reg || q_move;
    assign sts.cnt_one = (cnt_reg == LEN_W'(1));

    always_comb begin
        wq_next      = wq_reg;
        wofs_next    = wofs_reg;
        rp_next      = rp_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        empty_next   = empty_reg;
        grant_next   = grant_reg;
        avail_next   = avail_reg;
        if (cmd.wr) begin
            if (wofs_reg == OFS_MAX) begin
                wofs_next = '0;
                wq_next   = wq_inc;
                if (rp_reg[ADDR_W-1 -: Q_W] == wq_inc) begin
                    rp_next = {wq_inc + Q_W'(1), {OFS_W{1'b0}}};
                end
            end else begin
                wofs_next = wofs_reg + OFS_W'(1);
            end
        end
        if (cmd.fetch) begin
            rd_addr_next = from_back ? (w_idx - {{(ADDR_W-LEN_W){1'b0}}, g}) : rp_reg;
            cnt_next     = (g == '0) ? LEN_W'(1) : g;
            empty_next   = (g == '0);
            grant_next   = g;
            avail_next   = AVAIL_W'(avail_now);
            if (consume) begin
                rp_next = rp_reg + {{(ADDR_W-LEN_W){1'b0}}, g};
            end
        end
        if (cmd.issue) begin
            rd_addr_next = rd_addr_reg + ADDR_W'(1);
            cnt_next     = cnt_reg - LEN_W'(1);
        end
    end

    always_comb begin
        q_vld_next = q_vld_reg;
        if (cmd.issue) begin
            q_vld_next = 1'b1;
        end else if (q_move) begin
            q_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (q_move) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wq_reg      <= '0;
            wofs_reg    <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            q_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            wq_reg      <= wq_next;
            wofs_reg    <= wofs_next;
            rp_reg      <= rp_next;
            cnt_reg     <= cnt_next;
            q_vld_reg   <= q_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        empty_reg   <= empty_next;
        grant_reg   <= grant_next;
        avail_reg   <= avail_next;
        if (cmd.issue) begin
            q_last_reg   <= sts.cnt_one;
            q_dvalid_reg <= !empty_reg;
            q_grant_reg  <= grant_reg;
            q_avail_reg  <= avail_reg;
        end
        if (q_move) begin
            out_byte_reg   <= q_dvalid_reg ? mem_q_reg : '0;
            out_dvalid_reg <= q_dvalid_reg;
            out_last_reg   <= q_last_reg;
            out_grant_reg  <= q_grant_reg;
            out_avail_reg  <= q_avail_reg;
        end
    end

    // byte store
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[w_idx] <= rx_byte;
        end
        if (cmd.issue && !empty_reg) begin
            mem_q_reg <= mem[rd_addr_reg];
        end
    end

    assign m_valid         = out_vld_reg;
    assign data_byte       = out_byte_reg;
    assign data_valid      = out_dvalid_reg;
    assign granted_length  = out_grant_reg;
    assign bytes_available = out_avail_reg;
    assign last            = out_last_reg;

    a_issue_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (!q_vld_reg || q_move))
        else $error("read stage overwritten");

    a_grant_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |=> ({{(AVAIL_W-LEN_W){1'b0}}, grant_reg} <= avail_reg)
                      && (grant_reg <= MAX_FETCH_LEN))
        else $error("grant exceeds available or maximum");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_vld_reg && !q_dvalid_reg) |-> q_last_reg)
        else $error("empty grant not marked last");

    a_rp_quarter: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr && wofs_reg == OFS_MAX) |=> (rp_reg[ADDR_W-1 -: Q_W] != wq_reg))
        else $error("read pointer left in write quarter");

endmodule
